[hdl/assert_macros.svh]
// Assertion macros shared by the wildcard pattern hit counter RTL.
// Depends on nothing; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge while out of reset.
`define WPHC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising edge while out of reset.
`define WPHC_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/wphc_pkg.sv]
// Shared types and constants of the wildcard pattern hit counter.
// Used by wphc_match and the top level; depends on nothing.
package wphc_pkg;

	localparam int MaxPattern  = 16;
	localparam int LenW        = $clog2(MaxPattern + 1);
	localparam int IdxW        = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
	localparam int SymW        = 8;
	localparam int CfgW        = 64;
	localparam int CfgLenW     = 5;
	localparam int CfgIdxW     = 2;
	localparam int CountW      = 32;
	localparam int CharsPerReg = CfgW / SymW;
	localparam int PatChars    = 2 * CharsPerReg;

	localparam logic [SymW-1:0] Wildcard = 8'h2E;

	typedef logic [SymW-1:0] sym_t;
	typedef sym_t [MaxPattern-1:0] window_t;
	typedef sym_t [PatChars-1:0] pattern_t;

	typedef enum logic [CfgIdxW-1:0] {
		CfgPatLow  = 2'd0,
		CfgPatHigh = 2'd1,
		CfgPatLen  = 2'd2
	} cfg_idx_t;

	// Active pattern length and fill of the window after the newest symbol.
	typedef struct packed {
		logic [LenW-1:0] len;
		logic [LenW-1:0] fill;
	} match_ctl_t;

endpackage

[hdl/wphc_match.sv]
// Parallel window compare: one match flag per window position, and a single hit when all are set.
// Depends on wphc_pkg.
module wphc_match (
	input  wphc_pkg::window_t    window,
	input  wphc_pkg::pattern_t   pattern,
	input  wphc_pkg::match_ctl_t ctl,
	output logic                 hit
);

	logic [wphc_pkg::MaxPattern-1:0] pos_ok;

	// Window age a meets pattern char len-1-a; ages beyond len are ignored.
	always_comb begin
		logic [wphc_pkg::LenW-1:0] j_full;
		wphc_pkg::sym_t            p;
		for (int a = 0; a < wphc_pkg::MaxPattern; a++) begin
			j_full    = ctl.len - wphc_pkg::LenW'(1) - wphc_pkg::LenW'(a);
			p         = pattern[j_full[wphc_pkg::IdxW-1:0]];
			pos_ok[a] = (wphc_pkg::LenW'(a) >= ctl.len) || (p == wphc_pkg::Wildcard)
				|| (window[a] == p);
		end
	end

	assign hit = (ctl.fill >= ctl.len) && (&pos_ok);

endmodule

[hdl/wildcard_pattern_hit_counter.sv]
// Wildcard pattern hit counter: counts the places in a symbol stream where a gapped pattern of
// 1 to 16 characters matches ('.' matches any symbol), and emits the saturating 32-bit count
// with the last symbol of each sequence, then starts afresh. Throughput is one item per cycle
// while the input is not held: an item is staged in an input register, the whole window is
// compared against the pattern combinationally by wphc_match, and the count lands in an output
// register, from which a sequence's result is offered once its last item moves on. A pending result does
// not stop the block: only a second last item arriving while the previous count still waits
// holds the input. Sequences shorter than the pattern report zero. Pattern length 0 acts as 1,
// above 16 as 16. Program the pattern registers only while no item is in flight.
// Depends on wphc_pkg, wphc_match and assert_macros.svh.
`include "assert_macros.svh"

module wildcard_pattern_hit_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [wphc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [wphc_pkg::CfgW-1:0]           cfg_data,
	// symbol stream
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wphc_pkg::SymW-1:0]           symbol,
	input  logic                                last_symbol,
	// count results
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wphc_pkg::CountW-1:0]         hit_count
);

	// Configuration registers
	logic [wphc_pkg::CfgW-1:0]    pat_low_q;
	logic [wphc_pkg::CfgW-1:0]    pat_high_q;
	logic [wphc_pkg::CfgLenW-1:0] pat_len_q;

	// Input stage
	logic                         valid_s1;
	wphc_pkg::sym_t               symbol_s1;
	logic                         last_s1;

	// Sequence state
	wphc_pkg::window_t            window_q;
	logic [wphc_pkg::LenW-1:0]    fill_q;
	logic [wphc_pkg::CountW-1:0]  hits_q;

	// Result register
	logic                         out_valid_q;
	logic [wphc_pkg::CountW-1:0]  hit_count_q;

	wphc_pkg::window_t            win_next;
	wphc_pkg::pattern_t           pattern;
	wphc_pkg::match_ctl_t         ctl;
	logic [wphc_pkg::LenW-1:0]    len_eff;
	logic [wphc_pkg::CountW-1:0]  hits_next;
	logic                         hit;
	logic                         consume;

	// Decode configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= wphc_pkg::CfgLenW'(1);
		end else if (cfg_we) begin
			unique case (wphc_pkg::cfg_idx_t'(cfg_index))
				wphc_pkg::CfgPatLow:  pat_low_q  <= cfg_data;
				wphc_pkg::CfgPatHigh: pat_high_q <= cfg_data;
				wphc_pkg::CfgPatLen:  pat_len_q  <= cfg_data[wphc_pkg::CfgLenW-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the programmed length into 1..MaxPattern.
	always_comb begin
		if (pat_len_q == '0) begin
			len_eff = wphc_pkg::LenW'(1);
		end else if (pat_len_q > wphc_pkg::CfgLenW'(wphc_pkg::MaxPattern)) begin
			len_eff = wphc_pkg::LenW'(wphc_pkg::MaxPattern);
		end else begin
			len_eff = wphc_pkg::LenW'(pat_len_q);
		end
	end

	// Character 0 sits in the low byte of the low register.
	assign pattern = wphc_pkg::pattern_t'({pat_high_q, pat_low_q});

	// Shift the staged symbol in as the newest window entry.
	always_comb begin
		win_next[0] = symbol_s1;
		for (int k = 1; k < wphc_pkg::MaxPattern; k++) begin
			win_next[k] = window_q[k-1];
		end
	end

	assign ctl.len  = len_eff;
	assign ctl.fill = (fill_q == wphc_pkg::LenW'(wphc_pkg::MaxPattern)) ? fill_q
		: fill_q + wphc_pkg::LenW'(1);

	wphc_match u_match (
		.window  (win_next),
		.pattern (pattern),
		.ctl     (ctl),
		.hit     (hit)
	);

	// Count the hit, saturating at all ones.
	assign hits_next = (hit && (hits_q != '1)) ? hits_q + wphc_pkg::CountW'(1) : hits_q;

	// A staged item moves on unless it carries a result and the result slot stays full.
	assign consume  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			symbol_s1 <= symbol;
			last_s1   <= last_symbol;
		end
	end

	// Advance the sequence state; the last item clears it for the next sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hits_q <= '0;
		end else if (consume) begin
			if (last_s1) begin
				fill_q <= '0;
				hits_q <= '0;
			end else begin
				fill_q <= ctl.fill;
				hits_q <= hits_next;
			end
		end
	end

	// Window entries beyond the fill never affect a hit, so they need no clearing.
	always_ff @(posedge clk) begin
		if (consume) begin
			window_q <= win_next;
		end
		if (consume && last_s1) begin
			hit_count_q <= hits_next;
		end
	end

	// Hold the result until taken; a new result may replace one taken in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_count = hit_count_q;

	`WPHC_ASSERT(a_fill_bounded, clk, arst_n, fill_q <= wphc_pkg::LenW'(wphc_pkg::MaxPattern), "fill count beyond window depth")
	`WPHC_ASSERT(a_last_yields_result, clk, arst_n, (consume && last_s1) |=> out_valid, "last item gave no result")
	`WPHC_ASSERT(a_last_clears_state, clk, arst_n, (consume && last_s1) |=> (fill_q == '0 && hits_q == '0), "sequence state not cleared")
	`WPHC_NEVER(a_stall_needs_item, clk, arst_n, !in_ready && !(valid_s1 && last_s1 && out_valid_q), "input held without a blocked result")

endmodule

[verif/tb_top.sv]
// Testbench for wildcard_pattern_hit_counter: directed and random symbol streams checked
// against an in-bench model of the window, fill and hit count, under random idling and stalls.
// Depends on wphc_pkg and the RTL of the block; needs no other files.
module tb_top;
	import wphc_pkg::*;

	// Register index that has no register behind it; a write there must change nothing.
	localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
	localparam int          MaxReports  = 10;
	localparam int          DrainLimit  = 5000;
	localparam int          LongHold    = 300;
	localparam int          RandomItems = 800;
	// Letters that most random content is drawn from, so that matches are frequent.
	localparam logic [31:0] Bases       = "ACGT";

	typedef enum int {RxOpen, RxCoin, RxSparse, RxPeriodic} rx_mode_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgW-1:0]     cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [SymW-1:0]     symbol;
	logic                last_symbol;
	logic                out_valid;
	logic                out_ready;
	logic [CountW-1:0]   hit_count;

	// Model copy of the configuration and of the per-sequence state.
	logic [CfgW-1:0]     pat_lo;
	logic [CfgW-1:0]     pat_hi;
	logic [CfgLenW-1:0]  pat_len;
	window_t             hist;
	int unsigned         held;
	logic [CountW-1:0]   run_hits;

	// Hit counts the block still owes, oldest first.
	logic [CountW-1:0]   expected_counts[$];
	int unsigned         mismatches;

	// Sender and receiver controls.
	int unsigned         burst_left;
	bit                  sender_gaps;
	int unsigned         random_items;
	bit                  long_hold_req;

	wildcard_pattern_hit_counter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.symbol      (symbol),
		.last_symbol (last_symbol),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit_count   (hit_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Active length: 0 acts as 1, anything above the window depth acts as the full depth.
	function automatic int unsigned active_len();
		int unsigned n;
		n = 32'(pat_len);
		if (n == 0) n = 1;
		if (n > MaxPattern) n = MaxPattern;
		return n;
	endfunction

	function automatic sym_t pattern_at(input int unsigned j);
		if (j < CharsPerReg) return pat_lo[SymW*j +: SymW];
		return pat_hi[SymW*(j-CharsPerReg) +: SymW];
	endfunction

	// Shift one accepted symbol into the window, count a hit when the newest symbols match,
	// and on the last symbol queue the count and clear for the next sequence.
	// Pattern character 0 lines up with the oldest symbol of the compared window.
	function automatic void advance_window(input sym_t s, input logic last);
		int unsigned n;
		bit          hit;
		sym_t        p;
		n = active_len();
		hist = {hist[MaxPattern-2:0], s};
		if (held < MaxPattern) held++;
		hit = (held >= n);
		for (int unsigned j = 0; j < n; j++) begin
			p = pattern_at(j);
			if (p != Wildcard && hist[n-1-j] != p) hit = 1'b0;
		end
		if (hit && run_hits != '1) run_hits++;
		if (last) begin
			expected_counts.push_back(run_hits);
			hist = '0;
			held = 0;
			run_hits = '0;
		end
	endfunction

	task automatic log_failure(input string msg);
		if (mismatches < MaxReports) $display("%s", msg);
		mismatches++;
	endtask

	// Result checker: sample at the falling edge, so the values seen are the ones that the
	// next rising edge will take.
	always @(negedge clk) begin : check_counts
		logic [CountW-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_counts.size() == 0) begin
				log_failure($sformatf("hit_count %0d offered with no sequence pending",
					hit_count));
			end else begin
				want = expected_counts.pop_front();
				if (hit_count !== want)
					log_failure($sformatf("hit_count mismatch: expected %0d, got %0d",
						want, hit_count));
			end
		end
	end

	// Receiver: switch between stall patterns every so often; a long hold request from the
	// test holds ready low while a hold counter loaded from LongHold runs down here.
	initial begin : receiver
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned hold_left;
		int unsigned tick;
		mode = RxOpen;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LongHold;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(30, 150);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RxOpen:   out_ready <= 1'b1;
					RxCoin:   out_ready <= 1'($urandom_range(0, 1));
					RxSparse: out_ready <= ($urandom_range(0, 3) == 0);
					default:  out_ready <= ((tick % 8) < 5);
				endcase
			end
		end
	end

	// Offer one item and hold it until accepted. Bursts of random length are separated by
	// random gaps when gaps are enabled; the item is predicted once acceptance is certain.
	task automatic send_item(input sym_t s, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = sender_gaps ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		symbol <= s;
		last_symbol <= last;
		do @(negedge clk); while (!in_ready);
		advance_window(s, last);
		@(posedge clk);
	endtask

	task automatic send_sequence(ref sym_t seq[$]);
		foreach (seq[i]) send_item(seq[i], i == seq.size() - 1);
	endtask

	// Drop valid, wait for every owed count, then allow the pipeline to empty.
	task automatic settle();
		int unsigned waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_counts.size() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Drive one register write for one cycle; the caller settles first and drops cfg_we after.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CfgPatLow:  pat_lo = value;
			CfgPatHigh: pat_hi = value;
			CfgPatLen:  pat_len = value[CfgLenW-1:0];
			default:    ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_pattern(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi,
			input logic [CfgW-1:0] len_word);
		settle();
		write_reg(CfgPatLow, lo);
		write_reg(CfgPatHigh, hi);
		write_reg(CfgPatLen, len_word);
		cfg_we <= 1'b0;
	endtask

	// Length word with random upper bits, which the block must ignore.
	function automatic logic [CfgW-1:0] length_word(input logic [CfgLenW-1:0] n);
		logic [CfgW-1:0] w;
		w = {$urandom(), $urandom()};
		w[CfgLenW-1:0] = n;
		return w;
	endfunction

	function automatic sym_t random_base();
		return Bases[SymW*$urandom_range(0, 3) +: SymW];
	endfunction

	// Reset pattern is all zero bytes with length 1: every zero symbol is a hit.
	task automatic test_reset_pattern();
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	// Wildcard in the middle, a short sequence, length 0 and an overlong length.
	task automatic test_directed_cases();
		sym_t seq[$];
		// "AC.T", length 4; upper bytes are outside the active length
		load_pattern(64'hFFFF_FFFF_542E_4341, '1, length_word(5'd4));
		seq = '{8'h41, 8'h43, 8'hFF, 8'h54};
		send_sequence(seq);
		// shorter than the pattern: zero hits
		seq = '{8'h41};
		send_sequence(seq);
		// length 0 acts as 1; a '.' symbol does not match a literal 'A'
		load_pattern(64'h2E2E_2E2E_2E2E_2E41, 64'h0, length_word(5'd0));
		seq = '{8'h2E, 8'h41};
		send_sequence(seq);
		// write to the unused index, then length 31 with all wildcards acts as 16
		settle();
		write_reg(CfgSpare, '1);
		cfg_we <= 1'b0;
		load_pattern({8{Wildcard}}, {8{Wildcard}}, length_word(5'd31));
		seq.delete();
		for (int i = 0; i < MaxPattern; i++)
			seq.push_back((i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : Wildcard);
		send_sequence(seq);
	endtask

	// Random phases: each phase loads a random pattern and length, then streams sequences
	// made mostly of pattern letters with planted matches, plus some pure noise sequences.
	task automatic test_random_sequences();
		sym_t            chars[MaxPattern];
		sym_t            seq[$];
		logic [CfgW-1:0] lo;
		logic [CfgW-1:0] hi;
		logic [CfgLenW-1:0] n_cfg;
		int unsigned     eff;
		int unsigned     phase_items;
		int unsigned     phase_goal;
		int unsigned     n;
		int unsigned     r;
		bit              noise;
		while (random_items < RandomItems) begin
			r = $urandom_range(0, 9);
			case (r)
				0:       n_cfg = 5'd1;
				1:       n_cfg = 5'd16;
				2:       n_cfg = 5'd0;
				3:       n_cfg = CfgLenW'($urandom_range(17, 31));
				4, 5, 6: n_cfg = CfgLenW'($urandom_range(2, 6));
				default: n_cfg = CfgLenW'($urandom_range(1, 16));
			endcase
			for (int j = 0; j < MaxPattern; j++) begin
				r = $urandom_range(0, 19);
				if (r < 5) chars[j] = Wildcard;
				else if (r < 17) chars[j] = random_base();
				else chars[j] = sym_t'($urandom());
			end
			for (int j = 0; j < CharsPerReg; j++) begin
				lo[SymW*j +: SymW] = chars[j];
				hi[SymW*j +: SymW] = chars[j+CharsPerReg];
			end
			load_pattern(lo, hi, length_word(n_cfg));
			eff = active_len();
			sender_gaps = ($urandom_range(0, 3) != 0);
			phase_goal = $urandom_range(40, 120);
			phase_items = 0;
			while (phase_items < phase_goal) begin
				seq.delete();
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
				noise = ($urandom_range(0, 5) == 0);
				while (seq.size() < n) begin
					if (!noise && $urandom_range(0, 4) == 0 && n - seq.size() >= eff) begin
						// plant a full match; wildcard slots take any byte
						for (int j = 0; j < eff; j++)
							seq.push_back(chars[j] == Wildcard ? sym_t'($urandom()) : chars[j]);
					end else if (noise || $urandom_range(0, 4) == 0) begin
						seq.push_back(sym_t'($urandom()));
					end else if ($urandom_range(0, 1) == 0) begin
						seq.push_back(chars[$urandom_range(0, eff - 1)]);
					end else begin
						seq.push_back(random_base());
					end
				end
				send_sequence(seq);
				phase_items += seq.size();
				random_items += seq.size();
			end
		end
	endtask

	// Hold the receiver off for a long stretch while short sequences keep coming, so that
	// counts pile up and the block must stall its input.
	task automatic test_output_backpressure();
		sym_t seq[$];
		settle();
		sender_gaps = 1'b0;
		long_hold_req = 1'b1;
		for (int k = 0; k < 30; k++) begin
			seq.delete();
			repeat ($urandom_range(1, 2)) seq.push_back(random_base());
			send_sequence(seq);
		end
		sender_gaps = 1'b1;
	endtask

	initial begin : run
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		symbol = '0;
		last_symbol = 1'b0;
		pat_lo = '0;
		pat_hi = '0;
		pat_len = 5'd1;
		hist = '0;
		held = 0;
		run_hits = '0;
		mismatches = 0;
		burst_left = 0;
		sender_gaps = 1'b1;
		random_items = 0;
		long_hold_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pattern();
		test_directed_cases();
		test_random_sequences();
		test_output_backpressure();

		// drain, then wait on so that any stray count can show
		settle();
		repeat (8) @(posedge clk);
		if (expected_counts.size() != 0)
			log_failure($sformatf("%0d hit counts never arrived", expected_counts.size()));
		if (mismatches == 0) begin
			$display("[wildcard_pattern_hit_counter] OK");
		end else begin
			$display("[wildcard_pattern_hit_counter] ERROR");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		#2000000;
		$display("[wildcard_pattern_hit_counter] ERROR");
		$finish;
	end

endmodule
